FILE: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Holds the input/output word structs, command and operation codes.
// No dependencies.
package tcw_pkg;

	// Command codes on the input word
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Character codes with special handling
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_RETURN  = 8'd13;
	localparam logic [7:0] CHAR_BLANK   = 8'd32;

	// Attribute byte after reset
	localparam logic [7:0] COLOR_RESET = 8'h0F;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Input word
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} in_item_t;

	// Output word
	typedef struct packed {
		logic [6:0]  cursor_col_out;
		logic [4:0]  cursor_row_out;
		logic [15:0] cell_data;
	} out_item_t;

	// Classified operation handed to the back end
	typedef enum logic [2:0] {
		OP_CHAR    = 3'd0,
		OP_NEWLINE = 3'd1,
		OP_RETURN  = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_READ    = 3'd4,
		OP_NONE    = 3'd5
	} op_t;

	// Queue entry
	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
	} q_item_t;

endpackage

FILE: hw/rtl/tcw_front.sv
// Front end of the text console writer: classifies each input word.
// Turns command and character into an operation, range-checks reads.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     push_valid,
	input  logic     push_ready,
	output q_item_t  push_item
);

	logic rd_in_range;

	// Accept a word whenever the queue has room
	assign push_valid = in_valid;
	assign in_ready   = push_ready;

	// Check the read coordinates against the screen size
	assign rd_in_range = (8'(in_data.read_row) < 8'(ROWS)) &&
	                     (9'(in_data.read_col) < 9'(COLUMNS));

	// Classify the word
	always_comb begin
		push_item.ch  = in_data.char_code;
		push_item.row = in_data.read_row;
		push_item.col = in_data.read_col;
		unique case (in_data.cmd)
			CMD_PUT: begin
				if (in_data.char_code == CHAR_NEWLINE) begin
					push_item.op = OP_NEWLINE;
				end else if (in_data.char_code == CHAR_RETURN) begin
					push_item.op = OP_RETURN;
				end else begin
					push_item.op = OP_CHAR;
				end
			end
			CMD_CLEAR: push_item.op = OP_CLEAR;
			CMD_READ:  push_item.op = rd_in_range ? OP_READ : OP_NONE;
			default:   push_item.op = OP_NONE;
		endcase
	end

endmodule

FILE: hw/rtl/tcw_queue.sv
// Short command queue between the front and back ends.
// A small register FIFO of classified operations.
// Depends on tcw_pkg.
module tcw_queue import tcw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  q_item_t push_item,
	output logic    pop_valid,
	input  logic    pop_ready,
	output q_item_t pop_item
);

	q_item_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                push;
	logic                pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = ent_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(32'(wr_ptr_q) + 1 == QDEPTH ? 0 : 32'(wr_ptr_q) + 1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(32'(rd_ptr_q) + 1 == QDEPTH ? 0 : 32'(rd_ptr_q) + 1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Fill level never exceeds the queue depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue fill level beyond depth");

endmodule

FILE: hw/rtl/tcw_back.sv
// Back end of the text console writer: cursor, screen memory and sweeps.
// Executes queued operations and holds the result word register.
// Depends on tcw_pkg.
module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  q_item_t   pop_item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int CW     = $clog2(COLUMNS);
	localparam int RW     = $clog2(ROWS);
	localparam int CELLS  = COLUMNS * ROWS;
	localparam int AW     = $clog2(CELLS);
	localparam int COPY_N = COLUMNS * (ROWS - 1);

	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [AW-1:0] COPY_END  = AW'(COPY_N);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_COPY  = 5'b00100,
		ST_BLANK = 5'b01000,
		ST_CLEAR = 5'b10000
	} state_t;

	logic [15:0]   mem_q [CELLS];
	logic [15:0]   rd_data_q;
	state_t        state_q, state_d;
	logic [AW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [7:0]    color_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic          take;
	logic          load_out;
	logic [15:0]   out_cell;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] item_addr;
	logic [AW-1:0] copy_src;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Take a new operation only when idle and the result slot can drain
	assign pop_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign take      = pop_valid && pop_ready;

	// Cell addresses
	assign cur_addr  = AW'(AW'(row_q) * AW'(COLUMNS) + AW'(col_q));
	assign item_addr = AW'(AW'(pop_item.row) * AW'(COLUMNS) + AW'(pop_item.col));
	assign copy_src  = AW'((AW+1)'(cnt_q) + (AW+1)'(COLUMNS));

	// Sequence operations and sweeps
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		col_d    = col_q;
		row_d    = row_q;
		load_out = 1'b0;
		out_cell = '0;
		wr_en    = 1'b0;
		wr_addr  = cur_addr;
		wr_data  = {color_q, pop_item.ch};
		rd_en    = 1'b0;
		rd_addr  = item_addr;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (pop_item.op)
						OP_CHAR: begin
							wr_en = 1'b1;
							if (col_q == LAST_COL) begin
								col_d = '0;
								if (row_q == LAST_ROW) begin
									state_d = ST_COPY;
									cnt_d   = '0;
								end else begin
									row_d    = row_q + 1'b1;
									load_out = 1'b1;
								end
							end else begin
								col_d    = col_q + 1'b1;
								load_out = 1'b1;
							end
						end
						OP_NEWLINE: begin
							col_d = '0;
							if (row_q == LAST_ROW) begin
								state_d = ST_COPY;
								cnt_d   = '0;
							end else begin
								row_d    = row_q + 1'b1;
								load_out = 1'b1;
							end
						end
						OP_RETURN: begin
							col_d    = '0;
							load_out = 1'b1;
						end
						OP_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							state_d = ST_CLEAR;
							cnt_d   = '0;
						end
						OP_READ: begin
							rd_en   = 1'b1;
							state_d = ST_READ;
						end
						default: load_out = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				load_out = 1'b1;
				out_cell = rd_data_q;
				state_d  = ST_IDLE;
			end
			ST_COPY: begin
				// Read one row ahead, write the cell fetched last cycle
				rd_addr = copy_src;
				rd_en   = (cnt_q != COPY_END);
				wr_en   = (cnt_q != '0);
				wr_addr = cnt_q - 1'b1;
				wr_data = rd_data_q;
				if (cnt_q == COPY_END) begin
					state_d = ST_BLANK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_BLANK, ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = {color_q, CHAR_BLANK};
				if (cnt_q == LAST_CELL) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Screen memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.cursor_col_out <= 7'(col_d);
			out_q.cursor_row_out <= 5'(row_d);
			out_q.cell_data      <= out_cell;
		end
	end

	// Control state, cursor and color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			color_q     <= COLOR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			col_q   <= col_d;
			row_q   <= row_d;
			if (cfg_valid && cfg_ready) begin
				color_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Cursor column stays on screen
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < (CW+1)'(COLUMNS))
		else $error("cursor column off screen");

	// Cursor row stays on screen
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} < (RW+1)'(ROWS))
		else $error("cursor row off screen");

	// No result waits while a read or sweep is in progress
	a_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result slot busy during sweep");

endmodule

FILE: hw/rtl/text_console_writer_top.sv
// Text console writer: a character cell screen with cursor, scroll and clear.
// A put word that does not scroll completes in the idle state of the back end;
// a read also passes through the read state, for the registered read port of the
// screen memory. A newline or a wrap past the last row scrolls the screen by
// copying COLUMNS*(ROWS-1) cells through that memory and blanking the bottom
// row; a clear writes every cell. A two-word queue lets the input side keep
// taking words during a read or a sweep. Cells are undefined after reset;
// clear the screen before reading any cell.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
module text_console_writer_top import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic    push_valid;
	logic    push_ready;
	q_item_t push_item;
	logic    pop_valid;
	logic    pop_ready;
	q_item_t pop_item;

	// Classify incoming words
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item)
	);

	// Buffer classified operations
	tcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	// Execute operations against the screen
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

FILE: verif/testbench.sv
// Self-checking bench for text_console_writer_top: directed and random words,
// with a shadow screen and cursor in a small class that predicts each result word.
// Depends on tcw_pkg and the RTL of the text console writer.
`timescale 1ns / 100ps

module testbench import tcw_pkg::*;;

	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int CELLS         = COLUMNS * ROWS;
	// One full screen sweep plus margin: longest internal pass of the block
	localparam int SETTLE_CYCLES = CELLS + 100;
	localparam int STALL_LIMIT   = 20000;
	localparam int PHASE_WORDS   = 107;
	// Command code with no function in the block
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Shadow of the screen store and cursor; holds the result words still due
	class console_mirror;
		logic [15:0] cells [CELLS];
		int          col;
		int          row;
		logic [7:0]  color;
		out_item_t   due_words [$];
		int          failures;
		int          checked;
		int          puts;
		int          reads;
		int          clears;
		int          scrolls;

		function new();
			foreach (cells[i]) cells[i] = '0;
			col   = 0;
			row   = 0;
			color = COLOR_RESET;
		endfunction

		function void set_color(logic [7:0] c);
			color = c;
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		// Shift rows up, blank the bottom row, park the cursor on the last row
		function void scroll_screen();
			for (int i = 0; i < COLUMNS * (ROWS - 1); i++)
				cells[i] = cells[i + COLUMNS];
			for (int c = 0; c < COLUMNS; c++)
				cells[(ROWS - 1) * COLUMNS + c] = {color, CHAR_BLANK};
			row = ROWS - 1;
			scrolls++;
		endfunction

		function void next_row();
			col = 0;
			row++;
			if (row >= ROWS) begin
				scroll_screen();
			end
		endfunction

		// Update the shadow for one accepted word and queue its result
		function void apply_word(in_item_t w);
			out_item_t r;
			r.cell_data = '0;
			case (w.cmd)
				CMD_PUT: begin
					puts++;
					if (w.char_code == CHAR_NEWLINE) begin
						next_row();
					end else if (w.char_code == CHAR_RETURN) begin
						col = 0;
					end else begin
						cells[row * COLUMNS + col] = {color, w.char_code};
						col++;
						if (col >= COLUMNS) begin
							next_row();
						end
					end
				end
				CMD_CLEAR: begin
					clears++;
					foreach (cells[i]) cells[i] = {color, CHAR_BLANK};
					col = 0;
					row = 0;
				end
				CMD_READ: begin
					reads++;
					if (w.read_row < ROWS && w.read_col < COLUMNS) begin
						r.cell_data = cells[w.read_row * COLUMNS + w.read_col];
					end
				end
				default: begin
				end
			endcase
			r.cursor_col_out = col[6:0];
			r.cursor_row_out = row[4:0];
			due_words.push_back(r);
		endfunction

		// Compare one result word with the oldest prediction
		function void check_report(out_item_t got);
			out_item_t want;
			if (due_words.size() == 0) begin
				$error("unexpected result word: col %0d row %0d cell %h",
					got.cursor_col_out, got.cursor_row_out, got.cell_data);
				failures++;
				return;
			end
			want = due_words.pop_front();
			checked++;
			if (got.cursor_col_out !== want.cursor_col_out) begin
				$error("cursor_col_out: expected %0d, got %0d",
					want.cursor_col_out, got.cursor_col_out);
				failures++;
			end
			if (got.cursor_row_out !== want.cursor_row_out) begin
				$error("cursor_row_out: expected %0d, got %0d",
					want.cursor_row_out, got.cursor_row_out);
				failures++;
			end
			if (got.cell_data !== want.cell_data) begin
				$error("cell_data: expected %h, got %h", want.cell_data, got.cell_data);
				failures++;
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = '0;

	console_mirror mirror;
	bit            no_gaps     = 1'b0;
	int            line_left   = 0;
	int            stall_count = 0;
	int            colors_used = 0;

	text_console_writer_top #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Check each accepted result word; stall the output at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			mirror.check_report(out_data);
		end
		out_ready <= no_gaps || ($urandom_range(0, 99) >= 28);
	end

	// Count cycles without any accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
	end

	initial begin
		wait (stall_count >= STALL_LIMIT);
		$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	function automatic in_item_t make_word(logic [1:0] cmd, logic [7:0] ch,
		logic [4:0] rrow, logic [6:0] rcol);
		in_item_t w;
		w.cmd       = cmd;
		w.char_code = ch;
		w.read_row  = rrow;
		w.read_col  = rcol;
		return w;
	endfunction

	// Mostly lines of text ended by newline or return, with reads, rare clears and unused commands
	function automatic in_item_t random_word();
		in_item_t w;
		int       r;
		r           = $urandom_range(0, 999);
		w.char_code = 8'($urandom_range(0, 255));
		w.read_row  = 5'($urandom_range(0, 31));
		w.read_col  = 7'($urandom_range(0, 127));
		if (r < 3) begin
			w.cmd = CMD_CLEAR;
		end else if (r < 25) begin
			w.cmd = CMD_UNUSED;
		end else if (r < 225) begin
			w.cmd = CMD_READ;
			if ($urandom_range(0, 9) != 0) begin
				w.read_row = 5'($urandom_range(0, ROWS - 1));
				w.read_col = 7'($urandom_range(0, COLUMNS - 1));
			end
		end else begin
			w.cmd = CMD_PUT;
			if (line_left == 0) begin
				w.char_code = ($urandom_range(0, 4) == 0) ? CHAR_RETURN : CHAR_NEWLINE;
				line_left = ($urandom_range(0, 15) == 0) ? $urandom_range(70, 170)
					: $urandom_range(0, 4);
			end else begin
				line_left--;
				if ($urandom_range(0, 3) != 0)
					w.char_code = 8'($urandom_range(33, 126));
			end
		end
		return w;
	endfunction

	// Present one word after an optional random gap; hold until accepted
	task automatic send_word(input in_item_t w);
		while (!no_gaps && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		mirror.apply_word(w);
	endtask

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++)
			send_word(random_word());
		in_valid <= 1'b0;
	endtask

	// Wait for every predicted word, then for any sweep still running
	task automatic drain();
		while (mirror.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_color(input logic [7:0] c);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mirror.set_color(c);
		colors_used++;
	endtask

	initial begin
		mirror = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: no cell is read before the first clear
		send_word(make_word(CMD_PUT, 8'h41, 5'd0, 7'd0));
		send_word(make_word(CMD_UNUSED, 8'hFF, 5'h1F, 7'h7F));
		send_word(make_word(CMD_READ, 8'h00, 5'd31, 7'd127));
		send_word(make_word(CMD_CLEAR, 8'hFF, 5'h1F, 7'h7F));
		send_word(make_word(CMD_READ, 8'hFF, 5'd0, 7'd0));
		send_word(make_word(CMD_PUT, 8'hFF, 5'h1F, 7'h7F));
		send_word(make_word(CMD_PUT, 8'h00, 5'd0, 7'd0));
		send_word(make_word(CMD_PUT, 8'h80, 5'd0, 7'd0));
		send_word(make_word(CMD_PUT, 8'h7F, 5'd0, 7'd0));
		for (int c = 0; c < 4; c++)
			send_word(make_word(CMD_READ, 8'h00, 5'd0, 7'(c)));
		send_word(make_word(CMD_PUT, CHAR_RETURN, 5'd0, 7'd0));
		send_word(make_word(CMD_PUT, CHAR_NEWLINE, 5'd0, 7'd0));
		send_word(make_word(CMD_READ, 8'h00, 5'd24, 7'd79));
		send_word(make_word(CMD_READ, 8'h00, 5'd24, 7'd80));
		send_word(make_word(CMD_READ, 8'h00, 5'd25, 7'd0));
		send_word(make_word(CMD_READ, 8'h00, 5'd0, 7'd127));
		send_word(make_word(CMD_READ, 8'h00, 5'd31, 7'd0));
		send_word(make_word(CMD_PUT, 8'h5A, 5'd0, 7'd0));
		send_word(make_word(CMD_READ, 8'h00, 5'd1, 7'd0));
		in_valid <= 1'b0;
		drain();

		// Random phases, each under its own attribute byte
		write_color(8'h00);
		run_random(PHASE_WORDS);
		drain();

		no_gaps = 1'b1;
		write_color(8'hFF);
		run_random(PHASE_WORDS);
		drain();
		no_gaps = 1'b0;

		write_color(8'($urandom_range(1, 254)));
		run_random(PHASE_WORDS);
		drain();

		write_color(8'($urandom_range(1, 254)));
		run_random(PHASE_WORDS);
		drain();

		$display("Checked %0d result words: %0d puts, %0d reads, %0d clears, %0d scrolls",
			mirror.checked, mirror.puts, mirror.reads, mirror.clears, mirror.scrolls);
		$display("Attribute byte written %0d times, including 0x00 and 0xFF", colors_used);
		if (mirror.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_top.sv
verif/testbench.sv
